/* rtl/pfu_pkg.sv */
// pixel format unpacker package: source format codes, register indexes,
// sample size and mode codes and the pixel packing function; no dependencies
`default_nettype none

package pfu_pkg;

  typedef enum logic [3:0] {
    FMT_RGB8       = 4'd0,
    FMT_RGB16      = 4'd1,
    FMT_RGBA8      = 4'd2,
    FMT_RGBA16     = 4'd3,
    FMT_LUM1       = 4'd4,
    FMT_LUM2       = 4'd5,
    FMT_LUM4       = 4'd6,
    FMT_LUM8       = 4'd7,
    FMT_LUM16      = 4'd8,
    FMT_LUMALPHA8  = 4'd9,
    FMT_LUMALPHA16 = 4'd10,
    FMT_INDEX1     = 4'd11,
    FMT_INDEX2     = 4'd12,
    FMT_INDEX4     = 4'd13,
    FMT_INDEX8     = 4'd14,
    FMT_NONE       = 4'd15
  } fmt_t;

  typedef enum logic [1:0] {
    REG_SOURCE_FORMAT = 2'd0,
    REG_CHANNEL_ORDER = 2'd1,
    REG_ROW_WIDTH     = 2'd2,
    REG_PALETTE_COUNT = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    SZ1 = 2'd0,
    SZ2 = 2'd1,
    SZ4 = 2'd2,
    SZ8 = 2'd3
  } sz_t;

  typedef enum logic [1:0] {
    MODE_PIX = 2'd0,
    MODE_LUM = 2'd1,
    MODE_IDX = 2'd2
  } mode_t;

  localparam int CFG_DATA_W = 13;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  function automatic logic [31:0] make_pixel(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b, input logic [7:0] a,
                                             input logic swap);
    make_pixel = swap ? {a, r, g, b} : {a, b, g, r};
  endfunction

endpackage

`default_nettype wire

/* rtl/pfu_ram.sv */
// generic single write port ram with registered read and read enable
// no dependencies
`default_nettype none

module pfu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/pixel_format_unpacker.sv */
// Byte stream to 32-bit pixel converter. Each accepted data word issues its pixels one per
// cycle from the job stage while the palette read stage and result register can take them;
// 1-bit formats yield up to 8 pixels per word, issued one at a time through the single result
// register and the one palette read port. Pixels pass the job stage, the palette read stage and
// the result register. Palette writes yield nothing. Depends on pfu_pkg and pfu_ram.
`default_nettype none

module pixel_format_unpacker
  import pfu_pkg::*;
#(
  parameter int MAX_WIDTH     = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_kind,
  input  wire logic [7:0]            in_data_byte,
  input  wire logic                  in_start_of_frame,
  input  wire logic [7:0]            in_palette_index,
  input  wire logic [31:0]           in_palette_entry,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [31:0]                out_pixel,
  output logic                       out_last_of_run
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int WW = (CW > 13) ? CW : 13;
  localparam int AW = $clog2(PALETTE_DEPTH);

  // configuration
  logic [3:0]  fmt_r;
  logic        order_r;
  logic [12:0] row_width_r;
  logic [8:0]  pal_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r       <= FMT_RGBA8;
      order_r     <= 1'b0;
      row_width_r <= 13'd1;
      pal_count_r <= 9'd0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SOURCE_FORMAT: fmt_r       <= cfg_wdata[3:0];
        REG_CHANNEL_ORDER: order_r     <= cfg_wdata[0];
        REG_ROW_WIDTH:     row_width_r <= cfg_wdata[12:0];
        REG_PALETTE_COUNT: pal_count_r <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // unpack state
  logic [2:0]    phase_r, phase_nxt;
  logic [23:0]   partial_r, partial_nxt;
  logic [CW-1:0] col_r, col_nxt;

  // job stage
  logic          job_vld_r;
  mode_t         job_mode_r;
  sz_t           job_sz_r;
  logic [7:0]    job_data_r;
  logic [3:0]    job_cnt_r;
  logic [31:0]   job_pix_r;

  // palette read stage
  logic          b_vld_r;
  logic          b_pal_r;
  logic          b_zero_r;
  logic [31:0]   b_pix_r;
  logic          b_last_r;
  logic [31:0]   ram_rdata;

  // result register
  logic          out_valid_r;
  logic [31:0]   out_pixel_r;
  logic          out_last_r;

  logic c_load, b_adv, issue;
  assign c_load = b_vld_r && (!out_valid_r || out_ready);
  assign b_adv  = !b_vld_r || c_load;
  assign issue  = job_vld_r && b_adv;

  assign in_ready = !job_vld_r || ((job_cnt_r == 4'd1) && b_adv);

  logic acc, acc_data, pal_we;
  assign acc      = in_valid && in_ready;
  assign acc_data = acc && in_kind && (fmt_r != FMT_NONE);
  assign pal_we   = acc && !in_kind && ({1'b0, in_palette_index} < 9'(PALETTE_DEPTH));

  // per word decode
  logic          new_job;
  mode_t         new_mode;
  sz_t           new_sz;
  logic [3:0]    new_cnt;
  logic [31:0]   new_pix;

  logic          multi, sub;
  logic [2:0]    nchan;
  logic          step2;
  logic [3:0]    total, ph_ext, ph_inc;
  logic [2:0]    slot;
  logic          take;
  logic [3:0]    ppb;
  logic [WW-1:0] w_eff, col_ext, rem_w, col_sum;
  logic [7:0]    v;

  always_comb begin
    v        = in_data_byte;
    multi    = 1'b0;
    sub      = 1'b0;
    nchan    = 3'd1;
    step2    = 1'b0;
    new_mode = MODE_PIX;
    new_sz   = SZ8;
    unique case (fmt_r)
      FMT_RGB8:       begin multi = 1'b1; nchan = 3'd3; end
      FMT_RGB16:      begin multi = 1'b1; nchan = 3'd3; step2 = 1'b1; end
      FMT_RGBA8:      begin multi = 1'b1; nchan = 3'd4; end
      FMT_RGBA16:     begin multi = 1'b1; nchan = 3'd4; step2 = 1'b1; end
      FMT_LUM1:       begin sub = 1'b1; new_mode = MODE_LUM; new_sz = SZ1; end
      FMT_LUM2:       begin sub = 1'b1; new_mode = MODE_LUM; new_sz = SZ2; end
      FMT_LUM4:       begin sub = 1'b1; new_mode = MODE_LUM; new_sz = SZ4; end
      FMT_LUM8:       begin multi = 1'b1; end
      FMT_LUM16:      begin multi = 1'b1; step2 = 1'b1; end
      FMT_LUMALPHA8:  begin multi = 1'b1; nchan = 3'd2; end
      FMT_LUMALPHA16: begin multi = 1'b1; nchan = 3'd2; step2 = 1'b1; end
      FMT_INDEX1:     begin sub = 1'b1; new_mode = MODE_IDX; new_sz = SZ1; end
      FMT_INDEX2:     begin sub = 1'b1; new_mode = MODE_IDX; new_sz = SZ2; end
      FMT_INDEX4:     begin sub = 1'b1; new_mode = MODE_IDX; new_sz = SZ4; end
      FMT_INDEX8:     begin new_mode = MODE_IDX; end
      default: ;
    endcase

    // multi-byte pixels
    total  = step2 ? {nchan, 1'b0} : {1'b0, nchan};
    ph_ext = in_start_of_frame ? 4'd0 : {1'b0, phase_r};
    if (ph_ext >= total) begin
      ph_ext = 4'd0;
    end
    take   = step2 ? !ph_ext[0] : 1'b1;
    slot   = step2 ? ph_ext[3:1] : ph_ext[2:0];
    ph_inc = ph_ext + 4'd1;
    if (ph_inc >= total) begin
      ph_inc = 4'd0;
    end

    // sub-byte pixels
    unique case (new_sz)
      SZ1:     ppb = 4'd8;
      SZ2:     ppb = 4'd4;
      SZ4:     ppb = 4'd2;
      default: ppb = 4'd1;
    endcase
    if (row_width_r == 13'd0) begin
      w_eff = WW'(1);
    end else if (WW'(row_width_r) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(row_width_r);
    end
    col_ext = in_start_of_frame ? '0 : WW'(col_r);
    if (col_ext >= w_eff) begin
      col_ext = '0;
    end
    rem_w   = w_eff - col_ext;
    new_cnt = (rem_w > WW'(ppb)) ? ppb : rem_w[3:0];
    col_sum = col_ext + WW'(new_cnt);

    phase_nxt   = in_start_of_frame ? 3'd0 : phase_r;
    partial_nxt = partial_r;
    col_nxt     = in_start_of_frame ? '0 : col_r;
    new_job     = 1'b0;
    new_pix     = '0;

    if (multi) begin
      phase_nxt = ph_inc[2:0];
      if (take) begin
        if (slot == nchan - 3'd1) begin
          new_job = 1'b1;
          unique case (nchan)
            3'd1:    new_pix = make_pixel(v, v, v, ALPHA_OPAQUE, order_r);
            3'd2:    new_pix = make_pixel(partial_r[7:0], partial_r[7:0], partial_r[7:0],
                                          v, order_r);
            3'd3:    new_pix = make_pixel(partial_r[7:0], partial_r[15:8], v,
                                          ALPHA_OPAQUE, order_r);
            default: new_pix = make_pixel(partial_r[7:0], partial_r[15:8],
                                          partial_r[23:16], v, order_r);
          endcase
        end else begin
          case (slot)
            3'd0:    partial_nxt[7:0]   = v;
            3'd1:    partial_nxt[15:8]  = v;
            default: partial_nxt[23:16] = v;
          endcase
        end
      end
      new_cnt = 4'd1;
    end else if (sub) begin
      new_job = 1'b1;
      col_nxt = (col_sum >= w_eff) ? '0 : col_sum[CW-1:0];
    end else begin
      new_job = 1'b1;
      new_cnt = 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      partial_r <= '0;
      col_r     <= '0;
    end else if (acc_data) begin
      phase_r   <= phase_nxt;
      partial_r <= partial_nxt;
      col_r     <= col_nxt;
    end
  end

  // one pixel per cycle out of the job stage while the palette read stage can advance
  logic [7:0]  q;
  logic [7:0]  lum;
  logic [7:0]  data_shift;
  logic        q_oob;

  always_comb begin
    unique case (job_sz_r)
      SZ1: begin
        q          = {7'd0, job_data_r[7]};
        lum        = {8{job_data_r[7]}};
        data_shift = {job_data_r[6:0], 1'b0};
      end
      SZ2: begin
        q          = {6'd0, job_data_r[7:6]};
        lum        = {4{job_data_r[7:6]}};
        data_shift = {job_data_r[5:0], 2'd0};
      end
      SZ4: begin
        q          = {4'd0, job_data_r[7:4]};
        lum        = {2{job_data_r[7:4]}};
        data_shift = {job_data_r[3:0], 4'd0};
      end
      default: begin
        q          = job_data_r;
        lum        = job_data_r;
        data_shift = job_data_r;
      end
    endcase
    q_oob = ({1'b0, q} >= 9'(PALETTE_DEPTH)) || ({1'b0, q} >= pal_count_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_vld_r <= 1'b0;
    end else if (acc_data && new_job) begin
      job_vld_r <= 1'b1;
    end else if (issue && (job_cnt_r == 4'd1)) begin
      job_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_data && new_job) begin
      job_mode_r <= new_mode;
      job_sz_r   <= new_sz;
      job_data_r <= in_data_byte;
      job_cnt_r  <= new_cnt;
      job_pix_r  <= new_pix;
    end else if (issue) begin
      job_data_r <= data_shift;
      job_cnt_r  <= job_cnt_r - 4'd1;
    end
  end

  pfu_ram #(
    .WIDTH(32),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk  (clk),
    .we   (pal_we),
    .waddr(in_palette_index[AW-1:0]),
    .wdata(in_palette_entry),
    .re   (issue),
    .raddr(q[AW-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (issue) begin
      b_vld_r <= 1'b1;
    end else if (c_load) begin
      b_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b_pal_r  <= (job_mode_r == MODE_IDX);
      b_zero_r <= q_oob;
      b_last_r <= (job_cnt_r == 4'd1);
      b_pix_r  <= (job_mode_r == MODE_LUM) ?
                  make_pixel(lum, lum, lum, ALPHA_OPAQUE, order_r) : job_pix_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (c_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c_load) begin
      out_last_r <= b_last_r;
      if (!b_pal_r) begin
        out_pixel_r <= b_pix_r;
      end else if (b_zero_r) begin
        out_pixel_r <= '0;
      end else begin
        out_pixel_r <= make_pixel(ram_rdata[7:0], ram_rdata[15:8], ram_rdata[23:16],
                                  ram_rdata[31:24], order_r);
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel       = out_pixel_r;
  assign out_last_of_run = out_last_r;

  // checks
  a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    job_vld_r |-> (job_cnt_r != 4'd0))
    else $error("job held with no pixels left");

  a_accept_frees_job: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && job_vld_r) |-> ((job_cnt_r == 4'd1) && issue))
    else $error("word accepted while job stage still busy");

  a_column_bound: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(col_r) < WW'(MAX_WIDTH))
    else $error("column count past row width limit");

  a_last_closes_job: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && (job_cnt_r == 4'd1) && !(acc_data && new_job)) |=> !job_vld_r)
    else $error("job stage not released after last pixel");

endmodule

`default_nettype wire

/* tb/sv/pixel_format_unpacker_tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for pixel_format_unpacker: directed and random byte streams
// with palette loads, a behavioural predictor of the unpacking and a result scoreboard
// depends on pfu_pkg and the pixel_format_unpacker rtl

module pixel_format_unpacker_tb;
  import pfu_pkg::*;

  localparam int MAX_W  = 4096;
  localparam int SETTLE = 16;
  localparam int TARGET = 330;

  typedef struct {
    logic        kind;
    logic [7:0]  data;
    logic        sof;
    logic [7:0]  pidx;
    logic [31:0] pent;
  } word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [1:0]            cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_kind = 1'b0;
  logic [7:0]            in_data_byte = '0;
  logic                  in_start_of_frame = 1'b0;
  logic [7:0]            in_palette_index = '0;
  logic [31:0]           in_palette_entry = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [31:0]           out_pixel;
  logic                  out_last_of_run;

  pixel_format_unpacker DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_data_byte(in_data_byte), .in_start_of_frame(in_start_of_frame),
    .in_palette_index(in_palette_index), .in_palette_entry(in_palette_entry),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pixel(out_pixel), .out_last_of_run(out_last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register shadows
  fmt_t        fmt_q = FMT_RGBA8;
  logic        swap_q = 1'b0;
  logic [12:0] width_q = 13'd1;
  logic [8:0]  count_q = 9'd0;

  // unpacker state
  logic [31:0] pal_mem [256];
  int          phase_q = 0;
  logic [23:0] held_q = '0;
  int          col_q = 0;

  logic [31:0] pixels_due [$];
  logic        lasts_due [$];
  word_t       pending [$];
  bit          loaded [256];

  int    queued = 0;
  int    words_taken = 0;
  int    pixels_seen = 0;
  int    reg_writes = 0;
  int    mismatches = 0;
  int    cyc = 0;
  logic  steady;
  word_t nxt;
  logic [31:0] want_px;
  logic        want_last;

  assign steady = (cyc % 1500) >= 1200;

  always @(posedge clk) cyc <= cyc + 1;

  function automatic logic [31:0] pack_rgba(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b, input logic [7:0] a);
    return swap_q ? {a, r, g, b} : {a, b, g, r};
  endfunction

  function automatic logic [31:0] palette_pixel(input logic [7:0] idx);
    logic [31:0] e;
    if (idx >= count_q) return 32'd0;
    e = pal_mem[idx];
    return pack_rgba(e[7:0], e[15:8], e[23:16], e[31:24]);
  endfunction

  task automatic gather_channels(input logic [7:0] v, input int nchan, input int step);
    int          total;
    int          slot;
    logic [31:0] px;
    total = nchan * step;
    if (phase_q >= total) phase_q = 0;
    if (phase_q % step == 0) begin
      slot = phase_q / step;
      if (slot + 1 == nchan) begin
        case (nchan)
          1: px = pack_rgba(v, v, v, ALPHA_OPAQUE);
          2: px = pack_rgba(held_q[7:0], held_q[7:0], held_q[7:0], v);
          3: px = pack_rgba(held_q[7:0], held_q[15:8], v, ALPHA_OPAQUE);
          default: px = pack_rgba(held_q[7:0], held_q[15:8], held_q[23:16], v);
        endcase
        pixels_due.push_back(px);
        lasts_due.push_back(1'b1);
      end else begin
        held_q[slot*8 +: 8] = v;
      end
    end
    phase_q++;
    if (phase_q >= total) phase_q = 0;
  endtask

  task automatic spread_samples(input logic [7:0] v, input int bits, input bit indexed);
    int          w;
    int          n;
    int          ppb;
    int          mask;
    int          q;
    logic [7:0]  lum;
    logic [31:0] px;
    w = width_q;
    if (w == 0) w = 1;
    if (w > MAX_W) w = MAX_W;
    if (col_q >= w) col_q = 0;
    ppb = 8 / bits;
    n = w - col_q;
    if (n > ppb) n = ppb;
    mask = (1 << bits) - 1;
    for (int i = 0; i < n; i++) begin
      q = (v >> (8 - bits * (i + 1))) & mask;
      if (indexed) begin
        px = palette_pixel(q[7:0]);
      end else begin
        lum = 8'(q * (255 / mask));
        px = pack_rgba(lum, lum, lum, ALPHA_OPAQUE);
      end
      pixels_due.push_back(px);
      lasts_due.push_back(i == n - 1);
    end
    col_q += n;
    if (col_q >= w) col_q = 0;
  endtask

  task automatic unpack_word(input word_t wd);
    if (!wd.kind) begin
      pal_mem[wd.pidx] = wd.pent;
      return;
    end
    if (fmt_q == FMT_NONE) return;
    if (wd.sof) begin
      col_q = 0;
      phase_q = 0;
    end
    case (fmt_q)
      FMT_RGB8:       gather_channels(wd.data, 3, 1);
      FMT_RGB16:      gather_channels(wd.data, 3, 2);
      FMT_RGBA8:      gather_channels(wd.data, 4, 1);
      FMT_RGBA16:     gather_channels(wd.data, 4, 2);
      FMT_LUM1:       spread_samples(wd.data, 1, 1'b0);
      FMT_LUM2:       spread_samples(wd.data, 2, 1'b0);
      FMT_LUM4:       spread_samples(wd.data, 4, 1'b0);
      FMT_LUM8:       gather_channels(wd.data, 1, 1);
      FMT_LUM16:      gather_channels(wd.data, 1, 2);
      FMT_LUMALPHA8:  gather_channels(wd.data, 2, 1);
      FMT_LUMALPHA16: gather_channels(wd.data, 2, 2);
      FMT_INDEX1:     spread_samples(wd.data, 1, 1'b1);
      FMT_INDEX2:     spread_samples(wd.data, 2, 1'b1);
      FMT_INDEX4:     spread_samples(wd.data, 4, 1'b1);
      default: begin
        pixels_due.push_back(palette_pixel(wd.data));
        lasts_due.push_back(1'b1);
      end
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        unpack_word('{in_kind, in_data_byte, in_start_of_frame, in_palette_index,
                      in_palette_entry});
        words_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending.size() != 0 && (steady || $urandom_range(0, 99) >= 19)) begin
          nxt = pending.pop_front();
          in_valid <= 1'b1;
          in_kind <= nxt.kind;
          in_data_byte <= nxt.data;
          in_start_of_frame <= nxt.sof;
          in_palette_index <= nxt.pidx;
          in_palette_entry <= nxt.pent;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pixels_due.size() == 0) begin
          $error("out_pixel: expected no word, got %h", out_pixel);
          mismatches++;
        end else begin
          want_px = pixels_due.pop_front();
          want_last = lasts_due.pop_front();
          if (out_pixel !== want_px) begin
            $error("out_pixel: expected %h, got %h", want_px, out_pixel);
            mismatches++;
          end
          if (out_last_of_run !== want_last) begin
            $error("out_last_of_run: expected %b, got %b", want_last, out_last_of_run);
            mismatches++;
          end
          pixels_seen++;
        end
      end
      out_ready <= steady || ($urandom_range(0, 99) >= 19);
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [12:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_SOURCE_FORMAT: fmt_q = fmt_t'(val[3:0]);
      REG_CHANNEL_ORDER: swap_q = val[0];
      REG_ROW_WIDTH:     width_q = val;
      default:           count_q = val[8:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
  endtask

  task automatic push_data(input logic [7:0] v, input logic sof);
    pending.push_back('{1'b1, v, sof, 8'($urandom), 32'($urandom)});
    if (fmt_q != FMT_NONE) queued++;
  endtask

  task automatic push_pal(input logic [7:0] idx, input logic [31:0] ent);
    pending.push_back('{1'b0, 8'($urandom), 1'($urandom), idx, ent});
    loaded[idx] = 1'b1;
    queued++;
  endtask

  task automatic drain();
    while (pending.size() != 0 || in_valid || pixels_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // entries 0 to 15 are loaded before any random indexed phase
  function automatic logic [7:0] readable_index(input logic [7:0] v);
    if (v >= count_q || loaded[v]) return v;
    return v & 8'h0F;
  endfunction

  function automatic logic [12:0] pick_width();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 13'd0;
    if (r < 14) return 13'd4096;
    if (r < 20) return 13'd8191;
    if (r < 26) return 13'($urandom_range(4097, 8191));
    if (r < 32) return 13'($urandom_range(13, 4095));
    return 13'($urandom_range(1, 12));
  endfunction

  function automatic logic [12:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 13'd0;
    if (r < 20) return 13'd256;
    if (r < 28) return 13'd511;
    if (r < 35) return 13'($urandom_range(257, 510));
    if (r < 45) return 13'($urandom_range(17, 255));
    return 13'($urandom_range(1, 16));
  endfunction

  initial begin
    int   n;
    int   r;
    logic sof;
    logic [7:0] v;
    bit   first;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, one rgba pixel and a partial one
    push_data(8'h00, 1'b1);
    push_data(8'hFF, 1'b0);
    push_data(8'h12, 1'b0);
    push_data(8'h34, 1'b0);
    push_data(8'h80, 1'b0);
    drain();
    // format change mid pixel
    write_reg(REG_SOURCE_FORMAT, 13'(FMT_LUM8));
    push_data(8'hFF, 1'b0);
    push_data(8'h00, 1'b0);
    drain();
    write_reg(REG_SOURCE_FORMAT, 13'(FMT_LUM1));
    write_reg(REG_CHANNEL_ORDER, 13'd1);
    write_reg(REG_ROW_WIDTH, 13'd8191);
    write_reg(REG_PALETTE_COUNT, 13'd256);
    push_pal(8'd0, 32'h0000_0000);
    push_pal(8'd255, 32'hFFFF_FFFF);
    push_data(8'hA5, 1'b1);
    push_data(8'h00, 1'b0);
    push_data(8'hFF, 1'b0);
    drain();
    write_reg(REG_SOURCE_FORMAT, 13'(FMT_INDEX8));
    push_data(8'h00, 1'b1);
    push_data(8'hFF, 1'b0);
    drain();
    // everything at or above the count reads as zero
    write_reg(REG_PALETTE_COUNT, 13'd0);
    push_data(8'hFF, 1'b0);
    drain();
    write_reg(REG_SOURCE_FORMAT, 13'(FMT_NONE));
    push_data(8'h5A, 1'b1);
    drain();
    write_reg(REG_SOURCE_FORMAT, 13'(FMT_RGB16));
    write_reg(REG_ROW_WIDTH, 13'd3);
    for (int i = 0; i < 6; i++) push_data(8'($urandom), i == 0);
    drain();

    // random phases
    for (int i = 1; i < 16; i++) push_pal(i[7:0], $urandom);
    first = 1'b1;
    while (queued < TARGET) begin
      drain();
      if (first || $urandom_range(0, 99) < 60) begin
        if ($urandom_range(0, 99) < 5) write_reg(REG_SOURCE_FORMAT, 13'(FMT_NONE));
        else write_reg(REG_SOURCE_FORMAT, 13'($urandom_range(0, 14)));
      end
      if (first || $urandom_range(0, 99) < 50) write_reg(REG_CHANNEL_ORDER, 13'($urandom));
      if (first || $urandom_range(0, 99) < 40) write_reg(REG_ROW_WIDTH, pick_width());
      if (first || $urandom_range(0, 99) < 40) write_reg(REG_PALETTE_COUNT, pick_count());
      first = 1'b0;
      n = $urandom_range(8, 30);
      for (int k = 0; k < n; k++) begin
        r = $urandom_range(0, 99);
        if (r < 7 || (fmt_q == FMT_INDEX8 && r < 15)) begin
          push_pal(8'($urandom), $urandom);
        end else begin
          sof = (k == 0) ? ($urandom_range(0, 99) < 70) : ($urandom_range(0, 99) < 4);
          v = 8'($urandom);
          if (fmt_q == FMT_INDEX8) v = readable_index(v);
          push_data(v, sof);
        end
      end
    end
    drain();

    $display("ran %0d words through %0d register writes over all source formats,",
             words_taken, reg_writes);
    $display("and checked %0d pixels against the predicted stream", pixels_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* filelist.f */
rtl/pfu_pkg.sv
rtl/pfu_ram.sv
rtl/pixel_format_unpacker.sv
tb/sv/pixel_format_unpacker_tb.sv
